// File: hw/rtl/gsa_pkg.sv
// Shared types and constants for the group statistics accumulator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gsa_pkg;

  // Field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned GROUP_MAX = 4096;
  localparam int unsigned CNT_W     = 13;

  // Accumulator widths
  localparam int unsigned TSUM_W    = 44;
  localparam int unsigned VSUM_W    = 28;
  localparam int unsigned SQSUM_W   = 44;
  localparam int unsigned SQ_HALF   = SQSUM_W / 2;
  localparam int unsigned PROD_W    = CNT_W + SQSUM_W;
  localparam int unsigned VSQ_W     = 2 * VSUM_W;
  localparam int unsigned NN_W      = 2 * CNT_W - 1;

  // Divider and square root widths
  localparam int unsigned DIVN_W    = PROD_W + 16;
  localparam int unsigned DIVD_W    = VSUM_W;
  localparam int unsigned SQRT_IN_W = 50;
  localparam int unsigned SQRT_W    = SQRT_IN_W / 2;

  // Result widths
  localparam int unsigned MT_W      = 40;
  localparam int unsigned MV_W      = 24;
  localparam int unsigned RMS_W     = 24;
  localparam int unsigned ERR_W     = 24;
  localparam int unsigned RANGE_W   = 16;
  localparam int unsigned RATIO_W   = 32;
  localparam int unsigned OUT_W     = MT_W + MV_W + RMS_W + ERR_W + RANGE_W + 2 * RATIO_W;
  localparam int unsigned IN_W      = TIME_W + VALUE_W;

  localparam logic [CFG_W-1:0]   GROUP_SIZE_RST = CFG_W'(16);
  localparam logic [RATIO_W-1:0] RATIO_ONE      = RATIO_W'(65536);

  // One completed group handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic [TSUM_W-1:0]  tsum;
    logic [VSUM_W-1:0]  vsum;
    logic [SQSUM_W-1:0] sqsum;
    logic [VALUE_W-1:0] vmax;
    logic [VALUE_W-1:0] vmin;
  } group_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/gsa_front.sv
// Front end: accepts samples, accumulates sums, min and max, closes groups.
// Depends on gsa_pkg.
`default_nettype none

module gsa_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [gsa_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [gsa_pkg::TIME_W-1:0]   in_time,
  input  wire logic [gsa_pkg::VALUE_W-1:0]  in_value,
  input  wire gsa_pkg::queue_stat_t         q_stat,
  output logic                              push,
  output gsa_pkg::group_rec_t               rec
);

  logic [gsa_pkg::CFG_W-1:0]       gsize;
  logic [gsa_pkg::CNT_W-1:0]       cnt;
  logic [gsa_pkg::TSUM_W-1:0]      tsum;
  logic [gsa_pkg::VSUM_W-1:0]      vsum;
  logic [gsa_pkg::SQSUM_W-1:0]     sqsum;
  logic [gsa_pkg::VALUE_W-1:0]     vmax;
  logic [gsa_pkg::VALUE_W-1:0]     vmin;

  logic [gsa_pkg::CNT_W-1:0]       size_eff;
  logic [gsa_pkg::CNT_W-1:0]       cnt_next;
  logic [gsa_pkg::TSUM_W-1:0]      tsum_next;
  logic [gsa_pkg::VSUM_W-1:0]      vsum_next;
  logic [gsa_pkg::SQSUM_W-1:0]     sqsum_next;
  logic [gsa_pkg::VALUE_W-1:0]     vmax_next;
  logic [gsa_pkg::VALUE_W-1:0]     vmin_next;
  logic [2*gsa_pkg::VALUE_W-1:0]   vsq;
  logic                            accept;
  logic                            close;

  // Stall only when the queue has no room for a closed group
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Clamp the configured size into the legal range
  always_comb begin
    if (gsize == '0) begin
      size_eff = gsa_pkg::CNT_W'(1);
    end else if (gsize > gsa_pkg::CFG_W'(gsa_pkg::GROUP_MAX)) begin
      size_eff = gsa_pkg::CNT_W'(gsa_pkg::GROUP_MAX);
    end else begin
      size_eff = gsize;
    end
  end

  // Fold the new sample into the running totals
  always_comb begin
    vsq        = in_value * in_value;
    cnt_next   = cnt + gsa_pkg::CNT_W'(1);
    tsum_next  = tsum + gsa_pkg::TSUM_W'(in_time);
    vsum_next  = vsum + gsa_pkg::VSUM_W'(in_value);
    sqsum_next = sqsum + gsa_pkg::SQSUM_W'(vsq);
    vmax_next  = (in_value > vmax) ? in_value : vmax;
    vmin_next  = (in_value < vmin) ? in_value : vmin;
    close      = cnt_next >= size_eff;
  end

  assign push      = accept && close;
  assign rec.n     = cnt_next;
  assign rec.tsum  = tsum_next;
  assign rec.vsum  = vsum_next;
  assign rec.sqsum = sqsum_next;
  assign rec.vmax  = vmax_next;
  assign rec.vmin  = vmin_next;

  // Hold configuration and accumulators; clear after a group closes
  always_ff @(posedge clk) begin
    if (rst) begin
      gsize <= gsa_pkg::GROUP_SIZE_RST;
      cnt   <= '0;
      tsum  <= '0;
      vsum  <= '0;
      sqsum <= '0;
      vmax  <= '0;
      vmin  <= '1;
    end else begin
      if (cfg_wr_en) begin
        gsize <= cfg_wr_data;
      end
      if (accept) begin
        if (close) begin
          cnt   <= '0;
          tsum  <= '0;
          vsum  <= '0;
          sqsum <= '0;
          vmax  <= '0;
          vmin  <= '1;
        end else begin
          cnt   <= cnt_next;
          tsum  <= tsum_next;
          vsum  <= vsum_next;
          sqsum <= sqsum_next;
          vmax  <= vmax_next;
          vmin  <= vmin_next;
        end
      end
    end
  end

  a_cnt_below_max: assert property (@(posedge clk) disable iff (rst)
    cnt < gsa_pkg::CNT_W'(gsa_pkg::GROUP_MAX))
    else $error("group sample count reached its limit without closing");

endmodule

`default_nettype wire

// File: hw/rtl/gsa_queue.sv
// Two-entry queue of completed group records between front and back.
// Depends on gsa_pkg.
`default_nettype none

module gsa_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire gsa_pkg::group_rec_t  wr_rec,
  input  wire logic                 pop,
  output gsa_pkg::group_rec_t       rd_rec,
  output gsa_pkg::queue_stat_t      stat
);

  gsa_pkg::group_rec_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.full  = count == 2'd2;
  assign stat.valid = count != 2'd0;
  assign rd_rec     = mem[rd_ptr];

  // Store a record
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (!stat.full || pop))
    else $error("group record written into a full queue");

endmodule

`default_nettype wire

// File: hw/rtl/gsa_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gsa_pkg.
`default_nettype none

module gsa_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [gsa_pkg::DIVN_W-1:0]  dividend,
  input  wire logic [gsa_pkg::DIVD_W-1:0]  divisor,
  output logic                             busy,
  output logic                             done,
  output logic [gsa_pkg::DIVN_W-1:0]       quotient
);

  localparam int unsigned STEP_W = $clog2(gsa_pkg::DIVN_W + 1);

  logic [gsa_pkg::DIVD_W-1:0] dvs;
  logic [gsa_pkg::DIVD_W-1:0] rem;
  logic [STEP_W-1:0]          steps;
  logic [gsa_pkg::DIVD_W:0]   rem_sh;
  logic                       ge;
  logic [gsa_pkg::DIVD_W:0]   rem_sub;

  // Shift in one dividend bit and try the subtraction
  always_comb begin
    rem_sh  = {rem, quotient[gsa_pkg::DIVN_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= STEP_W'(gsa_pkg::DIVN_W);
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        rem      <= ge ? rem_sub[gsa_pkg::DIVD_W-1:0] : rem_sh[gsa_pkg::DIVD_W-1:0];
        quotient <= {quotient[gsa_pkg::DIVN_W-2:0], ge};
        steps    <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider finished without running");

endmodule

`default_nettype wire

// File: hw/rtl/gsa_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on gsa_pkg.
`default_nettype none

module gsa_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [gsa_pkg::SQRT_IN_W-1:0]  radicand,
  output logic                                done,
  output logic [gsa_pkg::SQRT_W-1:0]          root
);

  localparam int unsigned REM_W  = gsa_pkg::SQRT_W + 3;
  localparam int unsigned STEP_W = $clog2(gsa_pkg::SQRT_W + 1);

  logic [gsa_pkg::SQRT_IN_W-1:0] rad;
  logic [REM_W-1:0]              rem;
  logic [STEP_W-1:0]             steps;
  logic                          busy;
  logic [REM_W-1:0]              rem_sh;
  logic [REM_W-1:0]              trial;
  logic                          ge;

  // Bring down two radicand bits and test the next root bit
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[gsa_pkg::SQRT_IN_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(gsa_pkg::SQRT_W);
        rad   <= radicand;
        rem   <= '0;
        root  <= '0;
      end else if (busy) begin
        rem   <= ge ? (rem_sh - trial) : rem_sh;
        root  <= {root[gsa_pkg::SQRT_W-2:0], ge};
        rad   <= {rad[gsa_pkg::SQRT_IN_W-3:0], 2'b00};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gsa_back.sv
// Back end: turns one group record into means, spread, error, range, ratios.
// Depends on gsa_pkg, gsa_div and gsa_sqrt.
`default_nettype none

module gsa_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gsa_pkg::queue_stat_t       q_stat,
  input  wire gsa_pkg::group_rec_t        q_rec,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [gsa_pkg::OUT_W-1:0]       out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_MUL_B, S_DIFF,
    S_DIV_GO, S_DIV_WAIT, S_SQ_GO, S_SQ_WAIT, S_RMUL, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_MT, OP_MV, OP_X, OP_Y, OP_RR, OP_RG
  } op_t;

  state_t state;
  op_t    op;

  logic [gsa_pkg::CNT_W-1:0]    n;
  logic [gsa_pkg::TSUM_W-1:0]   tsum;
  logic [gsa_pkg::VSUM_W-1:0]   vsum;
  logic [gsa_pkg::SQSUM_W-1:0]  sqsum;
  logic [gsa_pkg::RANGE_W-1:0]  range;
  logic [gsa_pkg::PROD_W-1:0]   prod_a;
  logic [gsa_pkg::VSQ_W-1:0]    sq_b;
  logic [gsa_pkg::PROD_W-1:0]   d;
  logic [gsa_pkg::NN_W-1:0]     nn;
  logic [gsa_pkg::MT_W-1:0]     mt;
  logic [gsa_pkg::MV_W-1:0]     mv;
  logic [gsa_pkg::SQRT_W-1:0]   rms;
  logic [gsa_pkg::SQRT_W-1:0]   err;
  logic [gsa_pkg::RATIO_W-1:0]  rr;
  logic [gsa_pkg::RATIO_W-1:0]  rg;
  logic [gsa_pkg::SQRT_W+gsa_pkg::CNT_W-1:0]    rms_n;
  logic [gsa_pkg::RANGE_W+gsa_pkg::CNT_W-1:0]   range_n;
  logic [gsa_pkg::SQRT_IN_W-1:0] sq_in;

  logic [gsa_pkg::SQ_HALF+gsa_pkg::CNT_W-1:0]   pp;
  logic [gsa_pkg::DIVN_W-1:0]   div_dividend;
  logic [gsa_pkg::DIVD_W-1:0]   div_divisor;
  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  logic [gsa_pkg::DIVN_W-1:0]   div_q;
  logic [gsa_pkg::RATIO_W-1:0]  div_sat;
  logic                         sq_start;
  logic                         sq_done;
  logic [gsa_pkg::SQRT_W-1:0]   sq_root;
  logic                         load_out;

  gsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  gsa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign q_pop     = (state == S_IDLE) && q_stat.valid;
  assign div_start = state == S_DIV_GO;
  assign sq_start  = state == S_SQ_GO;
  assign load_out  = (state == S_OUT) && (!out_valid || out_ready);

  // Partial product of the size-weighted square sum, low or high half
  always_comb begin
    if (state == S_MUL_LO) begin
      pp = n * sqsum[gsa_pkg::SQ_HALF-1:0];
    end else begin
      pp = n * sqsum[gsa_pkg::SQSUM_W-1:gsa_pkg::SQ_HALF];
    end
  end

  // Select operands for the shared divider
  always_comb begin
    unique case (op)
      OP_MT: begin
        div_dividend = gsa_pkg::DIVN_W'({tsum, 8'b0});
        div_divisor  = gsa_pkg::DIVD_W'(n);
      end
      OP_MV: begin
        div_dividend = gsa_pkg::DIVN_W'({vsum, 8'b0});
        div_divisor  = gsa_pkg::DIVD_W'(n);
      end
      OP_X: begin
        div_dividend = {d, 16'b0};
        div_divisor  = gsa_pkg::DIVD_W'(nn);
      end
      OP_Y: begin
        div_dividend = gsa_pkg::DIVN_W'({vsum, 16'b0});
        div_divisor  = gsa_pkg::DIVD_W'(nn);
      end
      OP_RR: begin
        div_dividend = gsa_pkg::DIVN_W'({rms_n, 8'b0});
        div_divisor  = vsum;
      end
      OP_RG: begin
        div_dividend = gsa_pkg::DIVN_W'({range_n, 16'b0});
        div_divisor  = vsum;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = vsum;
      end
    endcase
  end

  // Saturate a ratio quotient to the field maximum
  assign div_sat = (|div_q[gsa_pkg::DIVN_W-1:gsa_pkg::RATIO_W]) ? '1 :
                   div_q[gsa_pkg::RATIO_W-1:0];

  // Sequence the per-group arithmetic and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_MT;
      out_valid <= 1'b0;
    end else begin
      // Drop valid after the transfer unless a new result replaces it
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_stat.valid) begin
            n     <= q_rec.n;
            tsum  <= q_rec.tsum;
            vsum  <= q_rec.vsum;
            sqsum <= q_rec.sqsum;
            range <= (q_rec.vmax >= q_rec.vmin) ? (q_rec.vmax - q_rec.vmin) : '0;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_a <= gsa_pkg::PROD_W'(pp);
          nn     <= gsa_pkg::NN_W'(n * n);
          state  <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_a <= prod_a + (gsa_pkg::PROD_W'(pp) << gsa_pkg::SQ_HALF);
          state  <= S_MUL_B;
        end
        S_MUL_B: begin
          sq_b  <= vsum * vsum;
          state <= S_DIFF;
        end
        S_DIFF: begin
          // Clamp a negative variance at zero
          d     <= (prod_a > gsa_pkg::PROD_W'(sq_b)) ? (prod_a - gsa_pkg::PROD_W'(sq_b)) : '0;
          op    <= OP_MT;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (op)
              OP_MT: begin
                mt    <= div_q[gsa_pkg::MT_W-1:0];
                op    <= OP_MV;
                state <= S_DIV_GO;
              end
              OP_MV: begin
                mv    <= div_q[gsa_pkg::MV_W-1:0];
                op    <= OP_X;
                state <= S_DIV_GO;
              end
              OP_X, OP_Y: begin
                sq_in <= div_q[gsa_pkg::SQRT_IN_W-1:0];
                state <= S_SQ_GO;
              end
              OP_RR: begin
                rr    <= div_sat;
                op    <= OP_RG;
                state <= S_DIV_GO;
              end
              OP_RG: begin
                rg    <= div_sat;
                state <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SQ_GO: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_done) begin
            if (op == OP_X) begin
              rms   <= sq_root;
              op    <= OP_Y;
              state <= S_DIV_GO;
            end else begin
              err   <= sq_root;
              state <= S_RMUL;
            end
          end
        end
        S_RMUL: begin
          rms_n   <= rms * n;
          range_n <= range * n;
          // Zero mean gives unit ratios
          if (vsum == '0) begin
            rr    <= gsa_pkg::RATIO_ONE;
            rg    <= gsa_pkg::RATIO_ONE;
            state <= S_OUT;
          end else begin
            op    <= OP_RR;
            state <= S_DIV_GO;
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_data  <= {rg, rr, range,
                          err[gsa_pkg::ERR_W-1:0], rms[gsa_pkg::RMS_W-1:0], mv, mt};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider result arrived while the sequencer was not waiting");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// File: hw/rtl/group_statistics_accumulator.sv
// Top level of the group statistics accumulator.
// Depends on gsa_pkg, gsa_front, gsa_queue and gsa_back.
//
// Samples enter on the s_axis channel, one transfer per sample, and are
// summed into groups of cfg group size (0 acts as 1, above 4096 as 4096).
// Each completed group yields one transfer on m_axis with mean time, mean
// value, rms spread, counting error, range and the two ratios; a trailing
// partial group yields nothing. The front end takes one sample per cycle.
// Each group costs the back end six divisions and two square roots on
// one divider and one root unit (four divisions when the value sum is
// zero). A two-entry queue of group records sits between them; when it
// is full, s_axis_tready drops until the back end takes a record. A
// result stalled by m_axis_tready waits in the output register while the
// next group is already computed. Reset clears the accumulators and the
// queue and sets group size to 16. Write the group size register with
// cfg_wr_en only while the block is idle; the block does not enforce it.
`default_nettype none

module group_statistics_accumulator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [gsa_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample_time[31:0], sample_value[47:32]
  input  wire logic [gsa_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // mean_time[39:0], mean_value[63:40], spread_rms[87:64],
  // count_error[111:88], value_range[127:112], ratio_rms[159:128],
  // ratio_range[191:160]
  output logic [gsa_pkg::OUT_W-1:0]        m_axis_tdata
);

  gsa_pkg::group_rec_t  push_rec;
  gsa_pkg::group_rec_t  head_rec;
  gsa_pkg::queue_stat_t q_stat;
  logic                 push;
  logic                 pop;

  gsa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_time     (s_axis_tdata[gsa_pkg::TIME_W-1:0]),
    .in_value    (s_axis_tdata[gsa_pkg::IN_W-1:gsa_pkg::TIME_W]),
    .q_stat      (q_stat),
    .push        (push),
    .rec         (push_rec)
  );

  gsa_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .rd_rec (head_rec),
    .stat   (q_stat)
  );

  gsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_rec     (head_rec),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire
